FILE: rtl/bpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy page allocator package
// Shared widths, command and status codes, counter file controls and helpers.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int RANK_LIMIT_DEF = 11;
  localparam int PAGE_BITS_DEF  = 12;

  localparam int CMD_W  = 3;
  localparam int RANK_W = 5;
  localparam int ADDR_W = 22;
  localparam int CNT_W  = 11;
  localparam int STAT_W = 2;
  localparam int CODE_W = 6;

  localparam logic [CNT_W-1:0] PAGE_COUNT_RST = 11'd1024;

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT  = 3'd0,
    CMD_ALLOC = 3'd1,
    CMD_FREE  = 3'd2,
    CMD_QRANK = 3'd3,
    CMD_QCNT  = 3'd4
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_NOSPACE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    FC_NONE  = 2'd0,
    FC_INC   = 2'd1,
    FC_DEC   = 2'd2,
    FC_CLEAR = 2'd3
  } fc_op_t;

  typedef struct packed {
    fc_op_t              op;
    logic [RANK_W-1:0]   idx;
  } fc_ctrl_t;

  // Number of significant bits of a value: the rank of the largest block that fits.
  function automatic logic [RANK_W-1:0] bit_len(input logic [15:0] v);
    logic [RANK_W-1:0] r;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      if (v[i]) begin
        r = RANK_W'(i + 1);
      end
    end
    return r;
  endfunction

endpackage

FILE: rtl/bpa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/bpa_free_cnt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Free block counter file
// One counter per rank with increment, decrement, clear and one read port.
// ----------------------------------------------------------------------------
module bpa_free_cnt
  import bpa_pkg::*;
#(
  parameter int RANK_LIMIT = RANK_LIMIT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  fc_ctrl_t          ctrl,
  input  logic [RANK_W-1:0] rd_idx,
  output logic [CNT_W-1:0]  rd_data
);

  localparam int IW = $clog2(RANK_LIMIT + 1);

  logic [CNT_W-1:0] cnt [RANK_LIMIT + 1];

  always_ff @(posedge clk) begin
    if (rst || ctrl.op == FC_CLEAR) begin
      for (int i = 0; i <= RANK_LIMIT; i++) begin
        cnt[i] <= '0;
      end
    end else begin
      unique case (ctrl.op)
        FC_INC:  cnt[ctrl.idx[IW-1:0]] <= cnt[ctrl.idx[IW-1:0]] + 1'b1;
        FC_DEC:  cnt[ctrl.idx[IW-1:0]] <= cnt[ctrl.idx[IW-1:0]] - 1'b1;
        default: ;
      endcase
    end
  end

  assign rd_data = (32'(rd_idx) <= RANK_LIMIT) ? cnt[rd_idx[IW-1:0]] : '0;

endmodule

FILE: rtl/buddy_page_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy page allocator
// Sequenced buddy allocator over a page rank RAM and a per-rank counter file.
// ----------------------------------------------------------------------------
//  Channel   Handshake             Payload
//  cfg       cfg_valid/cfg_ready   page_count
//  in        in_valid/in_ready     cmd, rank, address
//  out       out_valid/out_ready   status, block_address, answer
//
// Work per request: init lays out one block after another and writes every page;
// allocate scans blocks, counts one free half per split rank and rewrites every
// page of the found block; free takes merge steps and then rewrites every page of
// the merged block; a rank query reads the page RAM and a count query the counter
// file. All work is sequenced through the single RAM port pair.
// Reset clears control state, counters and the init flag; the page RAM is not
// cleared. A new request is taken in idle while a result still waits on out.
// ----------------------------------------------------------------------------
module buddy_page_allocator
  import bpa_pkg::*;
#(
  parameter int RANK_LIMIT = RANK_LIMIT_DEF,
  parameter int PAGE_BITS  = PAGE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CNT_W-1:0]  page_count,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CMD_W-1:0]  cmd,
  input  logic [RANK_W-1:0] rank,
  input  logic [ADDR_W-1:0] address,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [STAT_W-1:0] status,
  output logic [ADDR_W-1:0] block_address,
  output logic [CNT_W-1:0]  answer
);

  localparam int SLOTS = 1 << (RANK_LIMIT - 1);
  localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  // Offsets and page counts: wide enough to hold SLOTS and an offset plus a block.
  localparam int OW    = RANK_LIMIT;

  typedef enum logic [12:0] {
    S_IDLE      = 13'b0000000000001,
    S_INIT_PICK = 13'b0000000000010,
    S_FILL      = 13'b0000000000100,
    S_SCAN_TEST = 13'b0000000001000,
    S_SCAN_CHK  = 13'b0000000010000,
    S_SPLIT_CNT = 13'b0000000100000,
    S_SPLIT_WR  = 13'b0000001000000,
    S_FREE_RD   = 13'b0000010000000,
    S_FREE_CHK  = 13'b0000100000000,
    S_MRG_TEST  = 13'b0001000000000,
    S_MRG_CHK   = 13'b0010000000000,
    S_QRY_RD    = 13'b0100000000000,
    S_DONE      = 13'b1000000000000
  } state_t;

  state_t state, state_next;

  // Request context.
  cmd_t              op, op_next;
  logic [RANK_W-1:0] want, want_next;
  logic [RANK_W-1:0] cur, cur_next;
  logic [RANK_W-1:0] top_rank, top_rank_next;
  logic [OW-1:0]     off, off_next;
  logic [OW-1:0]     left, left_next;
  logic [OW-1:0]     run, run_next;
  logic [OW-1:0]     rel, rel_next;
  logic [CODE_W-1:0] code, code_next;
  logic [OW-1:0]     active, active_next;
  logic              initialized, initialized_next;
  logic [CNT_W-1:0]  arena_pages, arena_pages_next;
  // Set for a rank query whose address passed the checks.
  logic              qry_live, qry_live_next;

  // Staged result and the output register.
  logic [STAT_W-1:0] res_status, res_status_next;
  logic [ADDR_W-1:0] res_addr, res_addr_next;
  logic [CNT_W-1:0]  res_answer, res_answer_next;
  logic              out_valid_next;
  logic [STAT_W-1:0] status_next;
  logic [ADDR_W-1:0] block_address_next;
  logic [CNT_W-1:0]  answer_next;

  // RAM and counter file wiring.
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CODE_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [CODE_W-1:0] ram_rdata;
  fc_ctrl_t          fc_ctrl, fc_ctrl_next;
  logic [CNT_W-1:0]  fc_rdata;

  // Request decode in idle.
  logic [ADDR_W-1:0] page_mask;
  logic [ADDR_W-1:0] page_idx;
  logic              page_ok;
  logic              rank_ok;
  logic              in_fire;

  // Datapath helpers.
  logic [RANK_W-1:0] rd_rank;
  logic [OW-1:0]     rd_blk;
  logic [OW-1:0]     cur_blk;
  logic [OW-1:0]     want_blk;
  logic [OW-1:0]     top_blk;
  logic [OW-1:0]     buddy;
  logic [RANK_W-1:0] pick_rank;
  logic [OW-1:0]     pick_blk;
  logic [CODE_W-1:0] split_code;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;

  assign page_mask = ADDR_W'((32'd1 << PAGE_BITS) - 32'd1);
  assign page_idx  = address >> PAGE_BITS;
  assign page_ok   = initialized && ((address & page_mask) == '0) &&
                     (page_idx < ADDR_W'(active));
  assign rank_ok   = (rank != '0) && (32'(rank) <= RANK_LIMIT);

  // A block of rank r spans 2^(r-1) pages.
  assign rd_rank   = ram_rdata[RANK_W-1:0];
  assign rd_blk    = OW'(1) << (rd_rank - 1'b1);
  assign cur_blk   = OW'(1) << (cur - 1'b1);
  assign want_blk  = OW'(1) << (want - 1'b1);
  assign top_blk   = OW'(1) << (top_rank - 1'b1);
  assign buddy     = off ^ cur_blk;
  assign pick_rank = bit_len(16'(left));
  assign pick_blk  = OW'(1) << (pick_rank - 1'b1);

  // Pages of a split block: the allocated head, then free halves of rising rank.
  assign split_code = (rel < want_blk) ? {1'b0, want} : {1'b1, bit_len(16'(rel))};

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = off[AW-1:0];
    ram_wdata = code;
    ram_raddr = (state == S_MRG_TEST) ? buddy[AW-1:0] : off[AW-1:0];
    if (state == S_FILL) begin
      ram_we = 1'b1;
    end else if (state == S_SPLIT_WR) begin
      ram_we    = 1'b1;
      ram_waddr = AW'(off + rel);
      ram_wdata = split_code;
    end
  end

  always_comb begin
    state_next         = state;
    op_next            = op;
    want_next          = want;
    cur_next           = cur;
    top_rank_next      = top_rank;
    off_next           = off;
    left_next          = left;
    run_next           = run;
    rel_next           = rel;
    code_next          = code;
    active_next        = active;
    initialized_next   = initialized;
    arena_pages_next   = arena_pages;
    qry_live_next      = qry_live;
    res_status_next    = res_status;
    res_addr_next      = res_addr;
    res_answer_next    = res_answer;
    out_valid_next     = out_valid;
    status_next        = status;
    block_address_next = block_address;
    answer_next        = answer;
    fc_ctrl_next       = '{op: FC_NONE, idx: '0};

    if (cfg_valid && cfg_ready) begin
      arena_pages_next = page_count;
    end
    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end

    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          op_next         = cmd_t'(cmd);
          want_next       = rank;
          off_next        = OW'(page_idx);
          left_next       = '0;
          qry_live_next   = 1'b0;
          res_status_next = ST_INVALID;
          res_addr_next   = '0;
          res_answer_next = '0;
          state_next      = S_DONE;
          case (cmd)
            CMD_INIT: begin
              if (arena_pages != '0 && 32'(arena_pages) <= SLOTS) begin
                fc_ctrl_next     = '{op: FC_CLEAR, idx: '0};
                active_next      = OW'(arena_pages);
                left_next        = OW'(arena_pages);
                initialized_next = 1'b1;
                off_next         = '0;
                res_status_next  = ST_OK;
                state_next       = S_INIT_PICK;
              end
            end
            CMD_ALLOC: begin
              if (rank_ok) begin
                off_next   = '0;
                state_next = S_SCAN_TEST;
              end
            end
            CMD_FREE: begin
              if (page_ok) begin
                state_next = S_FREE_RD;
              end
            end
            CMD_QRANK: begin
              if (page_ok) begin
                qry_live_next = 1'b1;
                state_next    = S_QRY_RD;
              end
            end
            CMD_QCNT: begin
              if (rank_ok) begin
                res_status_next = ST_OK;
                res_answer_next = fc_rdata;
              end
            end
            default: ;
          endcase
        end
      end

      // Lay out the largest block that still fits.
      S_INIT_PICK: begin
        code_next    = {1'b1, pick_rank};
        run_next     = pick_blk;
        left_next    = left - pick_blk;
        fc_ctrl_next = '{op: FC_INC, idx: pick_rank};
        state_next   = S_FILL;
      end

      S_FILL: begin
        off_next = off + 1'b1;
        run_next = run - 1'b1;
        if (run == OW'(1)) begin
          state_next = (op == CMD_INIT && left != '0) ? S_INIT_PICK : S_DONE;
        end
      end

      S_SCAN_TEST: begin
        if (off < active) begin
          state_next = S_SCAN_CHK;
        end else begin
          res_status_next = ST_NOSPACE;
          state_next      = S_DONE;
        end
      end

      S_SCAN_CHK: begin
        if (rd_rank == '0 || 32'(rd_rank) > RANK_LIMIT) begin
          res_status_next = ST_NOSPACE;
          state_next      = S_DONE;
        end else if (ram_rdata[CODE_W-1] && rd_rank >= want) begin
          fc_ctrl_next    = '{op: FC_DEC, idx: rd_rank};
          top_rank_next   = rd_rank;
          cur_next        = rd_rank - 1'b1;
          rel_next        = '0;
          res_status_next = ST_OK;
          res_addr_next   = ADDR_W'(ADDR_W'(off) << PAGE_BITS);
          state_next      = (rd_rank > want) ? S_SPLIT_CNT : S_SPLIT_WR;
        end else begin
          off_next   = off + rd_blk;
          state_next = S_SCAN_TEST;
        end
      end

      // One free upper half for each rank below the found one, down to the wanted one.
      S_SPLIT_CNT: begin
        fc_ctrl_next = '{op: FC_INC, idx: cur};
        cur_next     = cur - 1'b1;
        if (cur == want) begin
          state_next = S_SPLIT_WR;
        end
      end

      S_SPLIT_WR: begin
        rel_next = rel + 1'b1;
        if (rel == top_blk - 1'b1) begin
          state_next = S_DONE;
        end
      end

      S_FREE_RD: begin
        state_next = S_FREE_CHK;
      end

      S_FREE_CHK: begin
        if (ram_rdata[CODE_W-1] || rd_rank == '0 || 32'(rd_rank) > RANK_LIMIT ||
            (off & (rd_blk - 1'b1)) != '0) begin
          state_next = S_DONE;
        end else begin
          cur_next        = rd_rank;
          res_status_next = ST_OK;
          state_next      = S_MRG_TEST;
        end
      end

      S_MRG_TEST: begin
        if (32'(cur) < RANK_LIMIT && buddy < active) begin
          state_next = S_MRG_CHK;
        end else begin
          fc_ctrl_next = '{op: FC_INC, idx: cur};
          code_next    = {1'b1, cur};
          run_next     = cur_blk;
          state_next   = S_FILL;
        end
      end

      S_MRG_CHK: begin
        if (ram_rdata == {1'b1, cur}) begin
          fc_ctrl_next = '{op: FC_DEC, idx: cur};
          off_next     = off & ~cur_blk;
          cur_next     = cur + 1'b1;
          state_next   = S_MRG_TEST;
        end else begin
          fc_ctrl_next = '{op: FC_INC, idx: cur};
          code_next    = {1'b1, cur};
          run_next     = cur_blk;
          state_next   = S_FILL;
        end
      end

      S_QRY_RD: begin
        state_next = S_DONE;
      end

      S_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase

    // A rank query takes its answer straight from the RAM read data.
    if (state == S_DONE && (!out_valid || out_ready)) begin
      out_valid_next     = 1'b1;
      status_next        = (qry_live && rd_rank != '0) ? ST_OK : res_status;
      block_address_next = res_addr;
      answer_next        = (qry_live && rd_rank != '0) ? CNT_W'(rd_rank) : res_answer;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      initialized <= 1'b0;
      active      <= '0;
      arena_pages <= PAGE_COUNT_RST;
      out_valid   <= 1'b0;
      fc_ctrl     <= '{op: FC_NONE, idx: '0};
    end else begin
      state       <= state_next;
      initialized <= initialized_next;
      active      <= active_next;
      arena_pages <= arena_pages_next;
      out_valid   <= out_valid_next;
      fc_ctrl     <= fc_ctrl_next;
    end
  end

  always_ff @(posedge clk) begin
    op            <= op_next;
    want          <= want_next;
    cur           <= cur_next;
    top_rank      <= top_rank_next;
    off           <= off_next;
    left          <= left_next;
    run           <= run_next;
    rel           <= rel_next;
    code          <= code_next;
    qry_live      <= qry_live_next;
    res_status    <= res_status_next;
    res_addr      <= res_addr_next;
    res_answer    <= res_answer_next;
    status        <= status_next;
    block_address <= block_address_next;
    answer        <= answer_next;
  end

  // The RAM read data stays valid through the wait in S_DONE because the read
  // address (off) does not change after S_QRY_RD.

  bpa_ram #(
    .WIDTH (CODE_W),
    .DEPTH (SLOTS)
  ) u_page_rank (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bpa_free_cnt #(
    .RANK_LIMIT (RANK_LIMIT)
  ) u_free_cnt (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (fc_ctrl),
    .rd_idx  (rank),
    .rd_data (fc_rdata)
  );

`ifndef SYNTHESIS
  a_write_in_arena: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> ((state == S_FILL) ? (off < active) : ((off + rel) < active)))
    else $error("page rank write outside the arena");

  a_init_sticky: assert property (@(posedge clk) disable iff (rst)
    initialized |=> initialized)
    else $error("init flag dropped without reset");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result presented outside the done state");
`endif

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy page allocator testbench
// Sends directed and random requests to the allocator through its valid/ready
// channels with random gaps and stalls, predicts every result with a local
// model of the rank store and the free counters, and checks each result.
// ----------------------------------------------------------------------------
module tb
  import bpa_pkg::*;
;

  localparam int RANKS      = RANK_LIMIT_DEF;
  localparam int SLOTS      = 1 << (RANKS - 1);
  localparam int FREE_BIT   = 5;
  localparam int WDOG_LIMIT = 60000;
  localparam int DRAIN_CYC  = 40;
  localparam logic [CMD_W-1:0] CMD_BAD_LO  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_BAD_MID = 3'd6;
  localparam logic [CMD_W-1:0] CMD_BAD_HI  = 3'd7;

  typedef struct {
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] block_address;
    logic [CNT_W-1:0]  answer;
  } alloc_result_t;

  // One row of the directed table. Rows with known_result set carry the
  // expected result typed in; the others take it from the predictor.
  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [RANK_W-1:0] rank;
    logic [ADDR_W-1:0] address;
    bit                known_result;
    status_t           status;
    logic [ADDR_W-1:0] block_address;
    logic [CNT_W-1:0]  answer;
  } dir_row_t;

  logic              clk;
  logic              rst;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CNT_W-1:0]  page_count;
  logic              in_valid;
  logic              in_ready;
  logic [CMD_W-1:0]  cmd;
  logic [RANK_W-1:0] rank;
  logic [ADDR_W-1:0] address;
  logic              out_valid;
  logic              out_ready;
  logic [STAT_W-1:0] status;
  logic [ADDR_W-1:0] block_address;
  logic [CNT_W-1:0]  answer;

  buddy_page_allocator dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .page_count   (page_count),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .rank         (rank),
    .address      (address),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .block_address(block_address),
    .answer       (answer)
  );

  // Local copy of the allocator state.
  logic [5:0]       pg_rank   [SLOTS];
  logic [CNT_W-1:0] free_cnt  [RANKS+1];
  int unsigned      arena_pages;
  bit               arena_ready;
  int unsigned      latched_pages;

  alloc_result_t    pending_results[$];
  logic [ADDR_W-1:0] live_blocks[$];
  int               errors;
  int               idle_cycles;
  bit               quiet;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned blk_pages(int unsigned r);
    return 1 << ((r - 1) & 15);
  endfunction

  function automatic void mark_pages(int unsigned off, int unsigned r, logic [5:0] code);
    for (int unsigned i = 0; i < blk_pages(r); i++) begin
      pg_rank[(off + i) % SLOTS] = code;
    end
  endfunction

  function automatic void add_free(int unsigned off, int unsigned r);
    mark_pages(off, r, 6'(r) | 6'(1 << FREE_BIT));
    free_cnt[r] = free_cnt[r] + 1'b1;
  endfunction

  // Translates a byte offset into a page index; fails for an unaligned or
  // out-of-arena address, or before the arena is laid out.
  function automatic bit addr_to_page(logic [ADDR_W-1:0] a, output int unsigned off);
    off = 32'(a >> PAGE_BITS_DEF);
    if (!arena_ready || a[PAGE_BITS_DEF-1:0] != '0) return 1'b0;
    return off < arena_pages && off < SLOTS;
  endfunction

  function automatic status_t lay_out_arena();
    int unsigned left;
    int unsigned off;
    left = latched_pages;
    off  = 0;
    if (left == 0 || left > SLOTS) return ST_INVALID;
    foreach (free_cnt[i]) free_cnt[i] = '0;
    foreach (pg_rank[i]) pg_rank[i] = '0;
    arena_pages = left;
    arena_ready = 1'b1;
    // Greedy tiling: the largest block that still fits, lowest offset first.
    while (left > 0) begin
      for (int r = RANKS; r >= 1; r--) begin
        if (blk_pages(r) <= left) begin
          add_free(off, r);
          off  += blk_pages(r);
          left -= blk_pages(r);
          break;
        end
      end
    end
    return ST_OK;
  endfunction

  function automatic status_t take_block(int unsigned want, output logic [ADDR_W-1:0] a);
    int unsigned off;
    int unsigned r;
    bit          found;
    off   = 0;
    r     = 0;
    found = 1'b0;
    a     = '0;
    if (want < 1 || want > RANKS) return ST_INVALID;
    while (off < arena_pages && off < SLOTS) begin
      r = 32'(pg_rank[off][4:0]);
      if (r == 0 || r > RANKS) break;
      if (pg_rank[off][FREE_BIT] && r >= want) begin
        found = 1'b1;
        break;
      end
      off += blk_pages(r);
    end
    if (!found) return ST_NOSPACE;
    free_cnt[r] = free_cnt[r] - 1'b1;
    while (r > want) begin
      r--;
      add_free(off + blk_pages(r), r);
    end
    mark_pages(off, want, 6'(want));
    a = ADDR_W'(off << PAGE_BITS_DEF);
    return ST_OK;
  endfunction

  function automatic status_t return_block(logic [ADDR_W-1:0] a);
    int unsigned off;
    int unsigned r;
    int unsigned cur;
    int unsigned buddy;
    if (!addr_to_page(a, off)) return ST_INVALID;
    r = 32'(pg_rank[off]);
    if (pg_rank[off][FREE_BIT] || r == 0 || r > RANKS) return ST_INVALID;
    if ((off & (blk_pages(r) - 1)) != 0) return ST_INVALID;
    cur = r;
    // Merge upward while the buddy is a whole free block of the same rank.
    while (cur < RANKS) begin
      buddy = off ^ blk_pages(cur);
      if (buddy >= arena_pages || buddy >= SLOTS) break;
      if (pg_rank[buddy] != (6'(cur) | 6'(1 << FREE_BIT))) break;
      free_cnt[cur] = free_cnt[cur] - 1'b1;
      if (buddy < off) off = buddy;
      cur++;
    end
    add_free(off, cur);
    return ST_OK;
  endfunction

  function automatic alloc_result_t predict_allocator(logic [CMD_W-1:0] c,
                                                      logic [RANK_W-1:0] r,
                                                      logic [ADDR_W-1:0] a);
    alloc_result_t res;
    int unsigned   off;
    logic [ADDR_W-1:0] got;
    res.status        = ST_INVALID;
    res.block_address = '0;
    res.answer        = '0;
    case (c)
      CMD_INIT: begin
        res.status = lay_out_arena();
      end
      CMD_ALLOC: begin
        res.status = take_block(32'(r), got);
        res.block_address = got;
      end
      CMD_FREE: begin
        res.status = return_block(a);
      end
      CMD_QRANK: begin
        if (addr_to_page(a, off) && pg_rank[off][4:0] != 0) begin
          res.answer = CNT_W'(pg_rank[off][4:0]);
          res.status = ST_OK;
        end
      end
      CMD_QCNT: begin
        if (r >= 1 && r <= RANKS) begin
          res.answer = free_cnt[r];
          res.status = ST_OK;
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // Mostly short gaps, a few long ones, none at all during quiet stretches.
  function automatic int pick_gap();
    if (quiet) return 0;
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2);
    return $urandom_range(10, 40);
  endfunction

  // Sends one request and records its expected result. The valid line is
  // left high after acceptance so the next request can follow back to back.
  task automatic send_request(logic [CMD_W-1:0] c, logic [RANK_W-1:0] r,
                              logic [ADDR_W-1:0] a, bit known, alloc_result_t typed);
    int            gap;
    alloc_result_t res;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd      = c;
    rank     = r;
    address  = a;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    res = predict_allocator(c, r, a);
    pending_results.push_back(known ? typed : res);
    // Track live blocks so that most frees hit a real allocation.
    if (res.status == ST_OK) begin
      if (c == CMD_INIT) live_blocks.delete();
      if (c == CMD_ALLOC) live_blocks.push_back(res.block_address);
      if (c == CMD_FREE) begin
        foreach (live_blocks[i]) begin
          if (live_blocks[i] == a) begin
            live_blocks.delete(i);
            break;
          end
        end
      end
    end
  endtask

  task automatic drop_request();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // The register is only written once every outstanding result has drained.
  task automatic write_page_count(logic [CNT_W-1:0] v);
    drop_request();
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
    page_count = v;
    cfg_valid  = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    latched_pages = 32'(v);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [ADDR_W-1:0] pick_address();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 7 && live_blocks.size() != 0)
      return live_blocks[$urandom_range(0, live_blocks.size() - 1)];
    if (sel < 9 && arena_pages != 0)
      return ADDR_W'($urandom_range(0, arena_pages - 1) << PAGE_BITS_DEF);
    return ADDR_W'($urandom);
  endfunction

  task automatic send_random_request();
    int                sel;
    logic [CMD_W-1:0]  c;
    logic [RANK_W-1:0] r;
    logic [ADDR_W-1:0] a;
    alloc_result_t     none;
    none = '{default: '0};
    sel  = $urandom_range(0, 99);
    r    = RANK_W'($urandom);
    a    = ADDR_W'($urandom);
    if (sel < 40) begin
      c = CMD_ALLOC;
      sel = $urandom_range(0, 19);
      if (sel < 16) r = RANK_W'($urandom_range(1, 3));
      else if (sel < 19) r = RANK_W'($urandom_range(1, RANKS));
    end else if (sel < 75) begin
      c = CMD_FREE;
      a = pick_address();
    end else if (sel < 85) begin
      c = CMD_QRANK;
      a = pick_address();
    end else if (sel < 95) begin
      c = CMD_QCNT;
      if ($urandom_range(0, 3) != 0) r = RANK_W'($urandom_range(0, RANKS + 1));
    end else if (sel < 97) begin
      c = CMD_INIT;
    end else begin
      c = CMD_W'($urandom_range(CMD_BAD_LO, CMD_BAD_HI));
    end
    send_request(c, r, a, 1'b0, none);
  endtask

  // Directed part: before init, the unknown commands, bad ranks and
  // addresses, a split and a full merge back to one top-rank block.
  dir_row_t dir_tab [] = '{
    '{CMD_QCNT,  5'd1,  22'd0,       1'b1, ST_OK,      22'd0, 11'd0},
    '{CMD_ALLOC, 5'd1,  22'd0,       1'b1, ST_NOSPACE, 22'd0, 11'd0},
    '{CMD_FREE,  5'd0,  22'd0,       1'b1, ST_INVALID, 22'd0, 11'd0},
    '{CMD_QRANK, 5'd0,  22'd0,       1'b1, ST_INVALID, 22'd0, 11'd0},
    '{CMD_BAD_LO, 5'd31, 22'h3FFFFF, 1'b1, ST_INVALID, 22'd0, 11'd0},
    '{CMD_BAD_MID, 5'd11, 22'h155555, 1'b1, ST_INVALID, 22'd0, 11'd0},
    '{CMD_BAD_HI, 5'd0, 22'h2AAAAA,  1'b1, ST_INVALID, 22'd0, 11'd0},
    '{CMD_INIT,  5'd0,  22'd0,       1'b1, ST_OK,      22'd0, 11'd0},
    '{CMD_QCNT,  5'd11, 22'd0,       1'b1, ST_OK,      22'd0, 11'd1},
    '{CMD_QCNT,  5'd0,  22'd0,       1'b1, ST_INVALID, 22'd0, 11'd0},
    '{CMD_QCNT,  5'd12, 22'd0,       1'b1, ST_INVALID, 22'd0, 11'd0},
    '{CMD_QCNT,  5'd31, 22'd0,       1'b1, ST_INVALID, 22'd0, 11'd0},
    '{CMD_ALLOC, 5'd0,  22'd0,       1'b1, ST_INVALID, 22'd0, 11'd0},
    '{CMD_ALLOC, 5'd12, 22'd0,       1'b1, ST_INVALID, 22'd0, 11'd0},
    '{CMD_ALLOC, 5'd1,  22'd0,       1'b1, ST_OK,      22'd0, 11'd0},
    '{CMD_QRANK, 5'd0,  22'd0,       1'b1, ST_OK,      22'd0, 11'd1},
    '{CMD_QRANK, 5'd0,  22'd1,       1'b1, ST_INVALID, 22'd0, 11'd0},
    '{CMD_QRANK, 5'd0,  22'h3FF000,  1'b0, ST_OK,      22'd0, 11'd0},
    '{CMD_QCNT,  5'd10, 22'd0,       1'b0, ST_OK,      22'd0, 11'd0},
    '{CMD_FREE,  5'd0,  22'h001000,  1'b0, ST_OK,      22'd0, 11'd0},
    '{CMD_FREE,  5'd0,  22'd0,       1'b1, ST_OK,      22'd0, 11'd0},
    '{CMD_FREE,  5'd0,  22'd0,       1'b1, ST_INVALID, 22'd0, 11'd0},
    '{CMD_ALLOC, 5'd11, 22'd0,       1'b1, ST_OK,      22'd0, 11'd0},
    '{CMD_ALLOC, 5'd1,  22'd0,       1'b1, ST_NOSPACE, 22'd0, 11'd0},
    '{CMD_FREE,  5'd0,  22'h3FF000,  1'b0, ST_OK,      22'd0, 11'd0}
  };

  // Arena sizes for the random phases: both limits, odd sizes, and three
  // counts that init must refuse.
  int unsigned phase_pages [] = '{1, 1024, 1000, 3, 0, 513, 2047, 1025, 77, 255};

  initial begin
    alloc_result_t typed;
    rst        = 1'b1;
    cfg_valid  = 1'b0;
    page_count = '0;
    in_valid   = 1'b0;
    cmd        = '0;
    rank       = '0;
    address    = '0;
    errors     = 0;
    arena_pages   = 0;
    arena_ready   = 1'b0;
    latched_pages = 32'(PAGE_COUNT_RST);
    foreach (pg_rank[i]) pg_rank[i] = '0;
    foreach (free_cnt[i]) free_cnt[i] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_tab[i]) begin
      typed.status        = dir_tab[i].status;
      typed.block_address = dir_tab[i].block_address;
      typed.answer        = dir_tab[i].answer;
      send_request(dir_tab[i].cmd, dir_tab[i].rank, dir_tab[i].address,
                   dir_tab[i].known_result, typed);
    end

    // Each phase sets a new arena size, lays it out, then runs random traffic.
    foreach (phase_pages[p]) begin
      write_page_count(CNT_W'(phase_pages[p]));
      typed = '{default: '0};
      send_request(CMD_INIT, RANK_W'($urandom), ADDR_W'($urandom), 1'b0, typed);
      repeat (24) send_random_request();
    end
    write_page_count(CNT_W'($urandom_range(1, SLOTS)));
    send_request(CMD_INIT, '0, '0, 1'b0, typed);
    repeat (20) send_random_request();

    drop_request();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Alternates stretches with gaps and stalls and stretches without them.
  initial begin
    quiet = 1'b0;
    forever begin
      repeat ($urandom_range(50, 300)) @(posedge clk);
      quiet = ($urandom_range(0, 3) == 0);
    end
  end

  // Result side back-pressure.
  initial begin
    int hold;
    bit rdy;
    hold      = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      rdy = 1'b1;
      if (hold > 0) begin
        hold--;
        rdy = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        hold = pick_gap();
        rdy  = (hold == 0);
      end
      out_ready = rdy;
    end
  end

  // Each accepted result is checked against the oldest expectation.
  always @(posedge clk) begin
    alloc_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d addr=%h answer=%0d",
                 $time, status, block_address, answer);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status);
          errors++;
        end
        if (block_address !== want.block_address) begin
          $display("%0t: block_address expected %h actual %h",
                   $time, want.block_address, block_address);
          errors++;
        end
        if (answer !== want.answer) begin
          $display("%0t: answer expected %0d actual %0d", $time, want.answer, answer);
          errors++;
        end
      end
    end
  end

  // Watchdog: ends the run when no channel has moved for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)
        || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

FILE: files.f
rtl/bpa_pkg.sv
rtl/bpa_ram.sv
rtl/bpa_free_cnt.sv
rtl/buddy_page_allocator.sv
verif/tb.sv
